### rtl/skn_pkg.sv
// Shared types, codes and helpers for the SPH smoothing kernel pipeline.
// No dependencies.
package skn_pkg;

    localparam int PRE_STAGES = 4;
    localparam int SQRT_CELLS = 32;
    localparam int DIV_CELLS  = 33;
    localparam int MUL_STAGES = 2;
    localparam int LAT = PRE_STAGES + SQRT_CELLS + 1 + DIV_CELLS + 3 * MUL_STAGES + 2;

    localparam logic [2:0] OP_POLY_1D       = 3'd0;
    localparam logic [2:0] OP_SPIKY_GRAD_1D = 3'd1;
    localparam logic [2:0] OP_SPIKY_LAP_1D  = 3'd2;
    localparam logic [2:0] OP_POLY_2D       = 3'd3;
    localparam logic [2:0] OP_SPIKY_GRAD_2D = 3'd4;
    localparam logic [2:0] OP_VISC_LAP_2D   = 3'd5;

    localparam logic [2:0] REG_RADIUS        = 3'd0;
    localparam logic [2:0] REG_POLY_1D       = 3'd1;
    localparam logic [2:0] REG_SPIKY_GRAD_1D = 3'd2;
    localparam logic [2:0] REG_SPIKY_LAP_1D  = 3'd3;
    localparam logic [2:0] REG_POLY_2D       = 3'd4;
    localparam logic [2:0] REG_SPIKY_GRAD_2D = 3'd5;
    localparam logic [2:0] REG_VISC_LAP_2D   = 3'd6;

    localparam logic [47:0] MAX47 = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MIN47 = 48'h8000_0000_0000;

    typedef struct packed {
        logic        big;
        logic [63:0] q;
    } skn_prod_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
    } skn_sqrt_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] quo;
        logic [31:0] dvs;
    } skn_div_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        xneg;
        logic        yneg;
        logic        in_sup;
        logic        nz;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [63:0] poly_a;
    } skn_side_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        xneg;
        logic        yneg;
        logic        in_sup;
        logic        nz;
        logic [63:0] poly_a;
        logic [63:0] aux;
        logic [32:0] qx;
        logic [32:0] qy;
        logic [63:0] p1;
    } skn_tail_t;

    typedef struct packed {
        logic neg_a;
        logic neg_b;
        logic keep_a;
        logic keep_b;
        logic in_sup;
    } skn_fin_t;

    function automatic logic [63:0] skn_sat64(input skn_prod_t p);
        return p.big ? 64'hFFFF_FFFF_FFFF_FFFF : p.q;
    endfunction

    function automatic logic [47:0] skn_scale(input skn_prod_t p, input logic neg);
        logic [63:0] nq;
        logic [47:0] res;
        nq = 64'd0 - p.q;
        if (!neg)
        begin
            res = (p.big || (p.q > {16'd0, MAX47})) ? MAX47 : p.q[47:0];
        end
        else
        begin
            res = (p.big || (p.q > {16'd0, MIN47})) ? MIN47 : nq[47:0];
        end
        return res;
    endfunction

endpackage

### rtl/skn_sqrt_cell.sv
// One step of the integer square root chain: one root bit per cell.
// Depends on skn_pkg.
module skn_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  skn_pkg::skn_sqrt_t din,
    output skn_pkg::skn_sqrt_t dout
);
    import skn_pkg::*;

    localparam int BIT_POS = 62 - 2 * STEP;
    localparam logic [63:0] BIT = 64'd1 << BIT_POS;

    skn_sqrt_t   cell_reg;
    skn_sqrt_t   cell_next;
    logic [63:0] trial;

    assign trial = din.root + BIT;

    always_comb
    begin
        if (din.rem >= trial)
        begin
            cell_next.rem  = din.rem - trial;
            cell_next.root = (din.root >> 1) + BIT;
        end
        else
        begin
            cell_next.rem  = din.rem;
            cell_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### rtl/skn_div_cell.sv
// One step of the restoring divider chain: one quotient bit per cell.
// Depends on skn_pkg.
module skn_div_cell (
    input  logic             clk,
    input  logic             en,
    input  logic             bit_in,
    input  skn_pkg::skn_div_t din,
    output skn_pkg::skn_div_t dout
);
    import skn_pkg::*;

    skn_div_t    cell_reg;
    skn_div_t    cell_next;
    logic [32:0] trial;
    logic [32:0] diff;

    assign trial = {din.rem, bit_in};
    assign diff  = trial - {1'b0, din.dvs};

    always_comb
    begin
        cell_next.dvs = din.dvs;
        if (trial >= {1'b0, din.dvs})
        begin
            cell_next.rem = diff[31:0];
            cell_next.quo = {din.quo[31:0], 1'b1};
        end
        else
        begin
            cell_next.rem = trial[31:0];
            cell_next.quo = {din.quo[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

### rtl/skn_mul.sv
// Two-stage 64x64 multiplier returning (a*b)>>32 and an overflow flag.
// Built from four 32x32 partial products. Depends on skn_pkg.
module skn_mul (
    input  logic              clk,
    input  logic              en,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output skn_pkg::skn_prod_t prod
);
    import skn_pkg::*;

    logic [63:0] pp_ll_reg;
    logic [63:0] pp_lh_reg;
    logic [63:0] pp_hl_reg;
    logic [63:0] pp_hh_reg;
    logic [33:0] mid;
    logic [63:0] hi;
    skn_prod_t   prod_reg;
    skn_prod_t   prod_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            pp_lh_reg <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
            pp_hl_reg <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            pp_hh_reg <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
        end
    end

    assign mid = {2'd0, pp_ll_reg[63:32]} + {2'd0, pp_lh_reg[31:0]} + {2'd0, pp_hl_reg[31:0]};
    assign hi  = pp_hh_reg + {32'd0, pp_lh_reg[63:32]} + {32'd0, pp_hl_reg[63:32]}
               + {62'd0, mid[33:32]};

    always_comb
    begin
        prod_next.q   = {hi[31:0], mid[31:0]};
        prod_next.big = |hi[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/sph_smoothing_kernels.sv
// SPH smoothing kernel evaluator: top level with config registers, pipeline and output skid.
// Depends on skn_pkg, skn_sqrt_cell, skn_div_cell, skn_mul.
//
//  channel | signals                               | direction
//  item    | item_valid item_stall op offset_x/y   | in (stall out)
//  result  | result_valid result_stall value_a/b   | out (stall in)
//          | inside_support                        |
//  config  | cfg_we cfg_index cfg_data             | in
//
// One item per cycle while the skid register is empty; the pipeline depth is set
// by the 32-cell square root chain, the 33-cell divider chain and the multiplier stages.
// Reset clears the valid chain, output and skid flags and the config registers.
// A result that arrives while the output holds a stalled result moves to the skid
// register; the pipeline holds while the skid register is full.
module sph_smoothing_kernels #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  op,
    input  logic signed [31:0] offset_x,
    input  logic signed [31:0] offset_y,
    output logic        result_valid,
    input  logic        result_stall,
    output logic signed [47:0] value_a,
    output logic signed [47:0] value_b,
    output logic        inside_support,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    import skn_pkg::*;

    localparam int FB2       = 2 * COORD_FRAC_BITS;
    localparam int AUX_SHIFT = 32 - COORD_FRAC_BITS;

    // configuration
    logic [30:0] radius_reg;
    logic [47:0] poly_1d_reg;
    logic [47:0] grad_1d_reg;
    logic [47:0] lap_1d_reg;
    logic [47:0] poly_2d_reg;
    logic [47:0] grad_2d_reg;
    logic [47:0] visc_2d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= '0;
            poly_1d_reg <= '0;
            grad_1d_reg <= '0;
            lap_1d_reg  <= '0;
            poly_2d_reg <= '0;
            grad_2d_reg <= '0;
            visc_2d_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS:        radius_reg  <= cfg_data[30:0];
                REG_POLY_1D:       poly_1d_reg <= cfg_data;
                REG_SPIKY_GRAD_1D: grad_1d_reg <= cfg_data;
                REG_SPIKY_LAP_1D:  lap_1d_reg  <= cfg_data;
                REG_POLY_2D:       poly_2d_reg <= cfg_data;
                REG_SPIKY_GRAD_2D: grad_2d_reg <= cfg_data;
                REG_VISC_LAP_2D:   visc_2d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    logic           adv;
    logic           accept;
    logic [LAT-1:0] vld_reg;
    logic           skid_vld_reg;
    logic           skid_vld_next;
    logic           out_vld_reg;
    logic           out_vld_next;

    assign adv        = !skid_vld_reg;
    assign item_stall = skid_vld_reg;
    assign accept     = item_valid && adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // P0: magnitudes and signs
    logic [31:0] ux;
    logic [31:0] uy;
    skn_side_t   s0_next;
    skn_side_t   s0_reg;

    assign ux = offset_x;
    assign uy = offset_y;

    always_comb
    begin
        s0_next.op     = op;
        s0_next.xneg   = ux[31];
        s0_next.yneg   = uy[31];
        s0_next.ax     = ux[31] ? (32'd0 - ux) : ux;
        s0_next.ay     = uy[31] ? (32'd0 - uy) : uy;
        s0_next.in_sup = 1'b0;
        s0_next.nz     = 1'b0;
        s0_next.poly_a = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= s0_next;
        end
    end

    // P1: squares
    skn_side_t   s1_reg;
    logic [63:0] ax2_reg;
    logic [63:0] ay2_reg;
    logic [63:0] h2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s0_reg;
            ax2_reg <= {32'd0, s0_reg.ax} * {32'd0, s0_reg.ax};
            ay2_reg <= {32'd0, s0_reg.ay} * {32'd0, s0_reg.ay};
            h2_reg  <= {33'd0, radius_reg} * {33'd0, radius_reg};
        end
    end

    // P2: squared length, 1D difference, 1D support test
    skn_side_t   s2_reg;
    logic [63:0] len2_reg;
    logic [63:0] d1_reg;
    logic [63:0] h2_p2_reg;
    logic        in1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg    <= s1_reg;
            len2_reg  <= ax2_reg + ay2_reg;
            d1_reg    <= h2_reg - ax2_reg;
            h2_p2_reg <= h2_reg;
            in1_reg   <= s1_reg.ax < {1'b0, radius_reg};
        end
    end

    // P3: 2D support test, poly6 base in Q.32
    logic [63:0] d2;
    logic [63:0] dsel;
    logic [63:0] poly_a_next;
    logic        in2;
    skn_side_t   s3_next;
    skn_side_t   s3_reg;
    skn_sqrt_t   sq_in_reg;

    assign in2  = len2_reg < h2_p2_reg;
    assign d2   = h2_p2_reg - len2_reg;
    assign dsel = (s2_reg.op == OP_POLY_2D) ? d2 : d1_reg;

    generate
        if (FB2 >= 32)
        begin : g_q_rshift
            assign poly_a_next = dsel >> (FB2 - 32);
        end
        else
        begin : g_q_lshift
            localparam int LS = 32 - FB2;
            assign poly_a_next = (|dsel[63:64-LS]) ? 64'hFFFF_FFFF_FFFF_FFFF : (dsel << LS);
        end
    endgenerate

    always_comb
    begin
        s3_next        = s2_reg;
        s3_next.poly_a = poly_a_next;
        s3_next.nz     = len2_reg != 64'd0;
        case (s2_reg.op)
            OP_POLY_1D, OP_SPIKY_GRAD_1D, OP_SPIKY_LAP_1D:  s3_next.in_sup = in1_reg;
            OP_POLY_2D, OP_SPIKY_GRAD_2D, OP_VISC_LAP_2D:   s3_next.in_sup = in2;
            default:                                        s3_next.in_sup = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg         <= s3_next;
            sq_in_reg.rem  <= len2_reg;
            sq_in_reg.root <= '0;
        end
    end

    // square root chain
    skn_sqrt_t sq_w [SQRT_CELLS+1];
    skn_side_t sq_side_reg [SQRT_CELLS];

    assign sq_w[0] = sq_in_reg;

    generate
        for (genvar j = 0; j < SQRT_CELLS; j++)
        begin : g_sqrt
            skn_sqrt_cell #(.STEP(j)) u_cell (
                .clk  (clk),
                .en   (adv),
                .din  (sq_w[j]),
                .dout (sq_w[j+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= s3_reg;
            for (int j = 1; j < SQRT_CELLS; j++)
            begin
                sq_side_reg[j] <= sq_side_reg[j-1];
            end
        end
    end

    // T0: distance to the radius and divider setup
    skn_side_t   sq_last;
    logic [31:0] len_w;
    logic [31:0] len_sel;
    logic [31:0] dl;
    skn_tail_t   t0_next;
    skn_tail_t   t0_reg;
    skn_div_t    t0_dx_reg;
    skn_div_t    t0_dy_reg;
    logic        t0_bx_reg;
    logic        t0_by_reg;

    assign sq_last = sq_side_reg[SQRT_CELLS-1];
    assign len_w   = sq_w[SQRT_CELLS].root[31:0];
    assign len_sel = (sq_last.op < OP_POLY_2D) ? sq_last.ax : len_w;
    assign dl      = {1'b0, radius_reg} - len_sel;

    always_comb
    begin
        t0_next.op     = sq_last.op;
        t0_next.xneg   = sq_last.xneg;
        t0_next.yneg   = sq_last.yneg;
        t0_next.in_sup = sq_last.in_sup;
        t0_next.nz     = sq_last.nz;
        t0_next.poly_a = sq_last.poly_a;
        t0_next.aux    = {32'd0, dl} << AUX_SHIFT;
        t0_next.qx     = '0;
        t0_next.qy     = '0;
        t0_next.p1     = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t0_reg        <= t0_next;
            t0_dx_reg.rem <= {1'b0, sq_last.ax[31:1]};
            t0_dx_reg.quo <= '0;
            t0_dx_reg.dvs <= len_w;
            t0_dy_reg.rem <= {1'b0, sq_last.ay[31:1]};
            t0_dy_reg.quo <= '0;
            t0_dy_reg.dvs <= len_w;
            t0_bx_reg     <= sq_last.ax[0];
            t0_by_reg     <= sq_last.ay[0];
        end
    end

    // divider chains for |x|/L and |y|/L
    skn_div_t  dx_w [DIV_CELLS+1];
    skn_div_t  dy_w [DIV_CELLS+1];
    skn_tail_t dv_tail_reg [DIV_CELLS];

    assign dx_w[0] = t0_dx_reg;
    assign dy_w[0] = t0_dy_reg;

    generate
        for (genvar j = 0; j < DIV_CELLS; j++)
        begin : g_div
            skn_div_cell u_cell_x (
                .clk    (clk),
                .en     (adv),
                .bit_in ((j == 0) ? t0_bx_reg : 1'b0),
                .din    (dx_w[j]),
                .dout   (dx_w[j+1])
            );
            skn_div_cell u_cell_y (
                .clk    (clk),
                .en     (adv),
                .bit_in ((j == 0) ? t0_by_reg : 1'b0),
                .din    (dy_w[j]),
                .dout   (dy_w[j+1])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_tail_reg[0] <= t0_reg;
            for (int j = 1; j < DIV_CELLS; j++)
            begin
                dv_tail_reg[j] <= dv_tail_reg[j-1];
            end
        end
    end

    // M1: square of the base
    skn_tail_t   m1_in;
    logic        m1_poly;
    logic [63:0] m1_a;
    skn_prod_t   m1_prod;
    skn_tail_t   m1_tail_reg [MUL_STAGES];

    always_comb
    begin
        m1_in    = dv_tail_reg[DIV_CELLS-1];
        m1_in.qx = dx_w[DIV_CELLS].quo;
        m1_in.qy = dy_w[DIV_CELLS].quo;
    end

    assign m1_poly = (m1_in.op == OP_POLY_1D) || (m1_in.op == OP_POLY_2D);
    assign m1_a    = m1_poly ? m1_in.poly_a : m1_in.aux;

    skn_mul u_mul1 (
        .clk  (clk),
        .en   (adv),
        .a    (m1_a),
        .b    (m1_a),
        .prod (m1_prod)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_tail_reg[0] <= m1_in;
            for (int j = 1; j < MUL_STAGES; j++)
            begin
                m1_tail_reg[j] <= m1_tail_reg[j-1];
            end
        end
    end

    // M2: cube or gradient direction
    skn_tail_t   m2_in;
    logic        m2_poly;
    logic [63:0] m2_bx;
    logic [63:0] m2_by;
    skn_prod_t   m2x_prod;
    skn_prod_t   m2y_prod;
    skn_tail_t   m2_tail_reg [MUL_STAGES];

    always_comb
    begin
        m2_in    = m1_tail_reg[MUL_STAGES-1];
        m2_in.p1 = skn_sat64(m1_prod);
    end

    assign m2_poly = (m2_in.op == OP_POLY_1D) || (m2_in.op == OP_POLY_2D);
    assign m2_bx   = m2_poly ? m2_in.poly_a : {31'd0, m2_in.qx};
    assign m2_by   = {31'd0, m2_in.qy};

    skn_mul u_mul2x (
        .clk  (clk),
        .en   (adv),
        .a    (m2_in.p1),
        .b    (m2_bx),
        .prod (m2x_prod)
    );

    skn_mul u_mul2y (
        .clk  (clk),
        .en   (adv),
        .a    (m2_in.p1),
        .b    (m2_by),
        .prod (m2y_prod)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_tail_reg[0] <= m2_in;
            for (int j = 1; j < MUL_STAGES; j++)
            begin
                m2_tail_reg[j] <= m2_tail_reg[j-1];
            end
        end
    end

    // C: coefficient select, magnitudes and signs
    skn_tail_t   c_in;
    logic [47:0] coef;
    logic [47:0] cm_next;
    logic [63:0] mag_a_next;
    skn_fin_t    fin_next;
    logic [47:0] c_cm_reg;
    logic [63:0] c_mag_a_reg;
    logic [63:0] c_mag_b_reg;
    skn_fin_t    c_fin_reg;

    assign c_in    = m2_tail_reg[MUL_STAGES-1];
    assign cm_next = coef[47] ? (48'd0 - coef) : coef;

    always_comb
    begin
        fin_next.in_sup = c_in.in_sup;
        fin_next.keep_a = c_in.in_sup && ((c_in.op != OP_SPIKY_GRAD_2D) || c_in.nz);
        fin_next.keep_b = c_in.in_sup && (c_in.op == OP_SPIKY_GRAD_2D) && c_in.nz;
        fin_next.neg_b  = 1'b0;
        case (c_in.op)
            OP_POLY_1D:
            begin
                coef           = poly_1d_reg;
                mag_a_next     = skn_sat64(m2x_prod);
                fin_next.neg_a = coef[47];
            end
            OP_SPIKY_GRAD_1D:
            begin
                coef           = grad_1d_reg;
                mag_a_next     = c_in.p1;
                fin_next.neg_a = !c_in.xneg ^ coef[47];
            end
            OP_SPIKY_LAP_1D:
            begin
                coef           = lap_1d_reg;
                mag_a_next     = c_in.aux;
                fin_next.neg_a = coef[47];
            end
            OP_POLY_2D:
            begin
                coef           = poly_2d_reg;
                mag_a_next     = skn_sat64(m2x_prod);
                fin_next.neg_a = coef[47];
            end
            OP_SPIKY_GRAD_2D:
            begin
                coef           = grad_2d_reg;
                mag_a_next     = skn_sat64(m2x_prod);
                fin_next.neg_a = c_in.xneg ^ coef[47];
                fin_next.neg_b = c_in.yneg ^ coef[47];
            end
            OP_VISC_LAP_2D:
            begin
                coef           = visc_2d_reg;
                mag_a_next     = c_in.aux;
                fin_next.neg_a = coef[47];
            end
            default:
            begin
                coef           = '0;
                mag_a_next     = '0;
                fin_next.neg_a = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_cm_reg    <= cm_next;
            c_mag_a_reg <= mag_a_next;
            c_mag_b_reg <= skn_sat64(m2y_prod);
            c_fin_reg   <= fin_next;
        end
    end

    // M3: coefficient products
    skn_prod_t m3a_prod;
    skn_prod_t m3b_prod;
    skn_fin_t  m3_fin_reg [MUL_STAGES];

    skn_mul u_mul3a (
        .clk  (clk),
        .en   (adv),
        .a    ({16'd0, c_cm_reg}),
        .b    (c_mag_a_reg),
        .prod (m3a_prod)
    );

    skn_mul u_mul3b (
        .clk  (clk),
        .en   (adv),
        .a    ({16'd0, c_cm_reg}),
        .b    (c_mag_b_reg),
        .prod (m3b_prod)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_fin_reg[0] <= c_fin_reg;
            for (int j = 1; j < MUL_STAGES; j++)
            begin
                m3_fin_reg[j] <= m3_fin_reg[j-1];
            end
        end
    end

    // F: saturation and gating
    skn_fin_t    f_in;
    logic [47:0] f_a_reg;
    logic [47:0] f_b_reg;
    logic        f_in_reg;

    assign f_in = m3_fin_reg[MUL_STAGES-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_a_reg  <= f_in.keep_a ? skn_scale(m3a_prod, f_in.neg_a) : '0;
            f_b_reg  <= f_in.keep_b ? skn_scale(m3b_prod, f_in.neg_b) : '0;
            f_in_reg <= f_in.in_sup;
        end
    end

    // output register and skid
    logic        push;
    logic        pop;
    logic [47:0] out_a_reg;
    logic [47:0] out_b_reg;
    logic        out_in_reg;
    logic [47:0] skid_a_reg;
    logic [47:0] skid_b_reg;
    logic        skid_in_reg;
    logic        load_out_f;
    logic        load_out_skid;
    logic        load_skid;

    assign push = vld_reg[LAT-1] && adv;
    assign pop  = out_vld_reg && !result_stall;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        load_out_f    = 1'b0;
        load_out_skid = 1'b0;
        load_skid     = 1'b0;
        if (pop && skid_vld_reg)
        begin
            load_out_skid = 1'b1;
            skid_vld_next = 1'b0;
        end
        else if (push && (!out_vld_reg || pop))
        begin
            load_out_f   = 1'b1;
            out_vld_next = 1'b1;
        end
        else if (push)
        begin
            load_skid     = 1'b1;
            skid_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_f)
        begin
            out_a_reg  <= f_a_reg;
            out_b_reg  <= f_b_reg;
            out_in_reg <= f_in_reg;
        end
        else if (load_out_skid)
        begin
            out_a_reg  <= skid_a_reg;
            out_b_reg  <= skid_b_reg;
            out_in_reg <= skid_in_reg;
        end
        if (load_skid)
        begin
            skid_a_reg  <= f_a_reg;
            skid_b_reg  <= f_b_reg;
            skid_in_reg <= f_in_reg;
        end
    end

    assign result_valid   = out_vld_reg;
    assign value_a        = out_a_reg;
    assign value_b        = out_b_reg;
    assign inside_support = out_in_reg;

`ifndef NO_ASSERTIONS
    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> result_valid)
        else $error("skid register full without a pending result");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !inside_support |-> (value_a == '0) && (value_b == '0))
        else $error("nonzero result outside support");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while held");

    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        push && result_valid && result_stall |=> skid_vld_reg)
        else $error("stalled transfer not captured in skid register");
`endif

endmodule
